### rtl/ethp_pkg.sv
package ethp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] frame_length;
    logic [15:0] payload_offset;
    logic [15:0] payload_length;
    logic [1:0]  stop_level;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [5:0]  tcp_flags;
    logic [1:0]  error_code;
  } out_item_t;

  localparam logic [15:0] ETH_HDR_LEN    = 16'd14;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  IPPROTO_TCP    = 8'd6;
  localparam logic [5:0]  MIN_HDR_LEN    = 6'd20;

  localparam logic [1:0] LAYER_ETH  = 2'd0;
  localparam logic [1:0] LAYER_IP   = 2'd1;
  localparam logic [1:0] LAYER_TCP  = 2'd2;
  localparam logic [1:0] LAYER_DONE = 2'd3;

  localparam logic [1:0] LEVEL_ETH = 2'd0;
  localparam logic [1:0] LEVEL_IP  = 2'd1;
  localparam logic [1:0] LEVEL_TCP = 2'd2;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_IP_SHORT  = 2'd1;
  localparam logic [1:0] ERR_TCP_SHORT = 2'd2;
  localparam logic [1:0] ERR_TRUNC     = 2'd3;

endpackage

### rtl/ethp_in_stage.sv
module ethp_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ethp_pkg::in_item_t in_item,
  input  logic              out_free,
  output logic              item_valid,
  output ethp_pkg::in_item_t item
);
  import ethp_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  // a final byte needs a free result slot; other bytes always move on
  assign item_valid = valid_r && (!item_r.last_byte || out_free);
  assign in_ready   = !valid_r || item_valid;
  assign item       = item_r;
  assign valid_nxt  = (in_valid && in_ready) || (valid_r && !item_valid);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

### rtl/ethp_parse_core.sv
module ethp_parse_core #(
  parameter int MAX_FRAME_BYTES = 65535
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  input  ethp_pkg::in_item_t item,
  output logic               res_valid,
  output ethp_pkg::out_item_t res
);
  import ethp_pkg::*;

  localparam logic [15:0] MAX_POS = 16'(MAX_FRAME_BYTES);

  typedef struct packed {
    logic [15:0] byte_pos;
    logic [1:0]  layer;
    logic [15:0] layer_start;
    logic [15:0] l2_type;
    logic [5:0]  ip_hdr_bytes;
    logic [7:0]  ip_proto;
    logic [5:0]  tcp_hdr_bytes;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [5:0]  flags;
    logic [1:0]  error;
  } state_t;

  state_t      st_r;
  state_t      st_upd;
  state_t      st_nxt;
  logic [15:0] rel;
  logic [15:0] rel_inc;
  logic [7:0]  b;
  logic [5:0]  ihl_bytes;
  logic [5:0]  doff_bytes;
  logic [15:0] etype_full;

  assign b          = item.data_byte;
  assign rel        = st_r.byte_pos - st_r.layer_start;
  assign rel_inc    = rel + 16'd1;
  assign ihl_bytes  = {b[3:0], 2'b00};
  assign doff_bytes = {b[7:4], 2'b00};
  assign etype_full = {st_r.l2_type[15:8], b};

  always_comb begin
    st_upd = st_r;
    if (item_valid && (st_r.byte_pos < MAX_POS)) begin
      st_upd.byte_pos = st_r.byte_pos + 16'd1;
      case (st_r.layer)
        LAYER_ETH: begin
          if (rel == 16'd12) begin
            st_upd.l2_type = {b, 8'h00};
          end else if (rel == 16'd13) begin
            st_upd.l2_type     = etype_full;
            st_upd.layer_start = ETH_HDR_LEN;
            st_upd.layer       = (etype_full == ETHERTYPE_IPV4) ? LAYER_IP : LAYER_DONE;
          end
        end
        LAYER_IP: begin
          if (rel == 16'd0) begin
            st_upd.ip_hdr_bytes = ihl_bytes;
            if (ihl_bytes < MIN_HDR_LEN) begin
              st_upd.error = ERR_IP_SHORT;
              st_upd.layer = LAYER_DONE;
            end
          end else begin
            if (rel == 16'd9) begin
              st_upd.ip_proto = b;
            end else if (rel >= 16'd12 && rel <= 16'd15) begin
              st_upd.src_addr = {st_r.src_addr[23:0], b};
            end else if (rel >= 16'd16 && rel <= 16'd19) begin
              st_upd.dst_addr = {st_r.dst_addr[23:0], b};
            end
            if (rel_inc == {10'd0, st_r.ip_hdr_bytes}) begin
              st_upd.layer_start = st_r.layer_start + {10'd0, st_r.ip_hdr_bytes};
              st_upd.layer = (st_upd.ip_proto == IPPROTO_TCP) ? LAYER_TCP : LAYER_DONE;
            end
          end
        end
        LAYER_TCP: begin
          if (rel == 16'd12) begin
            st_upd.tcp_hdr_bytes = doff_bytes;
            if (doff_bytes < MIN_HDR_LEN) begin
              st_upd.error = ERR_TCP_SHORT;
              st_upd.layer = LAYER_DONE;
            end
          end else begin
            if (rel <= 16'd1) begin
              st_upd.src_port = {st_r.src_port[7:0], b};
            end else if (rel <= 16'd3) begin
              st_upd.dst_port = {st_r.dst_port[7:0], b};
            end else if (rel <= 16'd7) begin
              st_upd.seq_num = {st_r.seq_num[23:0], b};
            end else if (rel <= 16'd11) begin
              st_upd.ack_num = {st_r.ack_num[23:0], b};
            end else if (rel == 16'd13) begin
              st_upd.flags = b[5:0];
            end
            if (rel_inc == {10'd0, st_r.tcp_hdr_bytes}) begin
              st_upd.layer_start = st_r.layer_start + {10'd0, st_r.tcp_hdr_bytes};
              st_upd.layer       = LAYER_DONE;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign res_valid = item_valid && item.last_byte;
  assign st_nxt    = res_valid ? '0 : st_upd;

  always_comb begin
    res.frame_length   = st_upd.byte_pos;
    res.payload_offset = st_upd.layer_start;
    res.payload_length = (st_upd.byte_pos > st_upd.layer_start) ?
                         (st_upd.byte_pos - st_upd.layer_start) : 16'd0;
    res.src_addr       = st_upd.src_addr;
    res.dst_addr       = st_upd.dst_addr;
    res.src_port       = st_upd.src_port;
    res.dst_port       = st_upd.dst_port;
    res.seq_num        = st_upd.seq_num;
    res.ack_num        = st_upd.ack_num;
    res.tcp_flags      = st_upd.flags;
    if (st_upd.layer != LAYER_DONE) begin
      res.error_code = ERR_TRUNC;
      res.stop_level = st_upd.layer;
    end else begin
      res.error_code = st_upd.error;
      if (st_upd.l2_type != ETHERTYPE_IPV4) begin
        res.stop_level = LEVEL_ETH;
      end else if (st_upd.ip_proto != IPPROTO_TCP) begin
        res.stop_level = LEVEL_IP;
      end else begin
        res.stop_level = LEVEL_TCP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

`ifndef SYNTHESIS
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> (st_r.byte_pos == 16'd0 && st_r.layer == LAYER_ETH))
    else $error("parser state not cleared after final byte");
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.byte_pos <= MAX_POS)
    else $error("byte position past frame limit");
  a_tcp_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.layer == LAYER_TCP) |->
      (st_r.l2_type == ETHERTYPE_IPV4 && st_r.ip_proto == IPPROTO_TCP))
    else $error("TCP layer entered without IPv4/TCP");
`endif

endmodule

### rtl/ethp_out_stage.sv
module ethp_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  ethp_pkg::out_item_t res,
  output logic                out_free,
  output logic                out_valid,
  input  logic                out_ready,
  output ethp_pkg::out_item_t out_item
);
  import ethp_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  out_item_t item_r;

  assign out_free  = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= res;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!valid_r || out_ready))
    else $error("result overwritten while stalled");
`endif

endmodule

### rtl/ethernet_ipv4_tcp_header_parser.sv
// Ethernet / IPv4 / TCP header parser.
// in_ channel: one frame byte per item, in wire order; last_byte marks the
// final byte of the frame. out_ channel: one header record per frame,
// produced for the final byte only.
// Throughput: one byte per cycle, back to back, across frame boundaries,
// as long as no final byte waits on a full result register.
// Each byte passes an input register, then the parse logic updates the
// header state and, on the final byte, loads the result register.
// Receiver stall: while a record waits in the result register, non-final
// bytes keep flowing; a final byte waits in the input register (in_ready
// low) until the record is taken.
// Reset (rst_n low, synchronous): both registers empty, parse state back to
// the start of a frame. Bytes beyond MAX_FRAME_BYTES are not counted or
// parsed, but last_byte still ends the frame.
module ethernet_ipv4_tcp_header_parser #(
  parameter int MAX_FRAME_BYTES = 65535
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ethp_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output ethp_pkg::out_item_t out_item
);
  import ethp_pkg::*;

  logic      out_free;
  logic      item_valid;
  in_item_t  item;
  logic      res_valid;
  out_item_t res;

  ethp_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_free  (out_free),
    .item_valid(item_valid),
    .item      (item)
  );

  ethp_parse_core #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_valid(item_valid),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  ethp_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (res_valid),
    .res      (res),
    .out_free (out_free),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

endmodule
